FILE: sv/wtpr_pkg.sv
// Package: shared constants, types and tables for the w-term phase rotation core.
`default_nettype none
package wtpr_pkg;
   localparam int GridSideMax  = 4096;
   localparam int CordicStages = 24;
   localparam int SqrtSteps    = 32;

   typedef enum logic [1:0] {
      REG_GRID_SIDE = 2'd0,
      REG_PIXEL     = 2'd1,
      REG_W         = 2'd2
   } reg_index_type;

   // Word carried between the rotator cells.
   typedef struct packed {
      logic               valid;
      logic               outside;
      logic signed [23:0] pass_re;
      logic signed [23:0] pass_im;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [33:0] z;
   } rot_word_type;

   // Word carried between the square-root cells.
   typedef struct packed {
      logic               valid;
      logic               outside;
      logic signed [23:0] re;
      logic signed [23:0] im;
      logic        [63:0] rem;
      logic        [31:0] root;
   } sqrt_word_type;

   function automatic logic [31:0] atan_turns(input int i);
      logic [31:0] t [0:31];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
      return t[i[4:0]];
   endfunction
endpackage
`default_nettype wire

FILE: sv/wtpr_if.sv
// Interfaces: valid/ready channels for sample and result words.
`default_nettype none
interface wtpr_req_if;
   logic               valid;
   logic               ready;
   logic        [11:0] row_index;
   logic        [11:0] column_index;
   logic signed [23:0] sample_re;
   logic signed [23:0] sample_im;
   modport source(output valid, row_index, column_index, sample_re, sample_im, input ready);
   modport sink(input valid, row_index, column_index, sample_re, sample_im, output ready);
endinterface

interface wtpr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] rotated_re;
   logic signed [23:0] rotated_im;
   logic               outside_sky;
   modport source(output valid, rotated_re, rotated_im, outside_sky, input ready);
   modport sink(input valid, rotated_re, rotated_im, outside_sky, output ready);
endinterface
`default_nettype wire

FILE: sv/w_term_phase_rotation_core.sv
// Top level: offsets, squares, square-root chain, phase, CORDIC chain and output.
//  channel | dir | payload
//  req_*   | in  | row_index, column_index, sample_re, sample_im
//  rsp_*   | out | rotated_re, rotated_im, outside_sky
//  csr_*   | in  | APB writes/reads of grid_side, pixel_size, w_wavelengths
// One word per cycle unless stalled; A-C, 32 sqrt cells, D-F, 24 CORDIC cells, output.
// The whole pipeline advances when the output register is empty or being taken.
// Synchronous reset clears all valid bits and restores the register defaults.
`default_nettype none
module w_term_phase_rotation_core (
   input  wire logic        clock,
   input  wire logic        reset,
   wtpr_req_if.sink         req,
   wtpr_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import wtpr_pkg::*;

   logic        [12:0] side_ff;
   logic        [31:0] pix_ff;
   logic signed [31:0] w_ff;
   logic advance;
   logic [1:0] ridx;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[3:2];
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= 13'd1024;
         pix_ff  <= '0;
         w_ff    <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (ridx)
            REG_GRID_SIDE: side_ff <= csr_pwdata[12:0];
            REG_PIXEL:     pix_ff  <= csr_pwdata;
            REG_W:         w_ff    <= csr_pwdata;
            default:       ;
         endcase
      end
   end
   always_comb begin
      csr_prdata = '0;
      unique case (ridx)
         REG_GRID_SIDE: csr_prdata = {19'd0, side_ff};
         REG_PIXEL:     csr_prdata = pix_ff;
         REG_W:         csr_prdata = w_ff;
         default:       csr_prdata = '0;
      endcase
   end

   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // Stage A: absolute offsets times pixel size.
   logic a_v_ff;
   logic signed [23:0] a_re_ff, a_im_ff;
   logic [44:0] am_ff, al_ff;
   logic [13:0] side_c;
   logic signed [14:0] dm, dl;
   logic [13:0] adm, adl;
   always_comb begin
      side_c = (side_ff > 13'(GridSideMax)) ? 14'(GridSideMax) : {1'b0, side_ff};
      dm  = $signed({2'b00, req.row_index, 1'b0}) - $signed({1'b0, side_c});
      dl  = $signed({2'b00, req.column_index, 1'b0}) - $signed({1'b0, side_c});
      adm = dm[14] ? 14'(-dm) : dm[13:0];
      adl = dl[14] ? 14'(-dl) : dl[13:0];
   end
   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (advance) a_v_ff <= req.valid;
      if (advance) begin
         am_ff <= 45'(adm) * 45'(pix_ff);
         al_ff <= 45'(adl) * 45'(pix_ff);
         a_re_ff <= req.sample_re;
         a_im_ff <= req.sample_im;
      end
   end

   // Stage B: floored squares in units of 2^-62.
   // Offsets below 2^33 keep their half within 32 bits; larger ones saturate.
   function automatic logic [63:0] sq62(input logic [44:0] a);
      logic [31:0] h;
      logic [63:0] p;
      h = a[32:1];
      p = h * h + (a[0] ? {32'd0, h} : 64'd0);
      if (a >= 45'h2_0000_0000) return 64'h4000_0000_0000_0000;
      return {2'b00, p[63:2]};
   endfunction
   logic b_v_ff, b_big_ff;
   logic signed [23:0] b_re_ff, b_im_ff;
   logic [63:0] sqm_ff, sql_ff;
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (advance) b_v_ff <= a_v_ff;
      if (advance) begin
         sqm_ff <= sq62(am_ff);
         sql_ff <= sq62(al_ff);
         b_big_ff <= (am_ff > 45'h2_0000_0000) || (al_ff > 45'h2_0000_0000);
         b_re_ff <= a_re_ff;
         b_im_ff <= a_im_ff;
      end
   end

   // Stage C: radius sum and outside test.
   sqrt_word_type sq_chain [0:SqrtSteps];
   logic [64:0] rsum;
   logic c_out;
   always_comb begin
      rsum  = {1'b0, sqm_ff} + {1'b0, sql_ff};
      c_out = b_big_ff || (rsum > 65'h4000_0000_0000_0000);
   end
   always_ff @(posedge clock) begin
      if (reset) sq_chain[0].valid <= 1'b0;
      else if (advance) sq_chain[0].valid <= b_v_ff;
      if (advance) begin
         sq_chain[0].outside <= c_out;
         sq_chain[0].re   <= b_re_ff;
         sq_chain[0].im   <= b_im_ff;
         sq_chain[0].rem  <= c_out ? 64'd0 : 64'h4000_0000_0000_0000 - rsum[63:0];
         sq_chain[0].root <= '0;
      end
   end

   // Square-root cell row, most significant bit first.
   for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
      wtpr_sqrt_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .bit_pos(6'(SqrtSteps - 1 - g)),
         .word_in(sq_chain[g]), .word_out(sq_chain[g+1]));
   end

   // Stage D: w times (sqrt - 1).
   sqrt_word_type sd;
   logic d_v_ff, d_out_ff;
   logic signed [23:0] d_re_ff, d_im_ff;
   logic signed [63:0] prod_ff;
   assign sd = sq_chain[SqrtSteps];
   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else if (advance) d_v_ff <= sd.valid;
      if (advance) begin
         prod_ff  <= w_ff * ($signed({1'b0, sd.root}) - 33'sh0_8000_0000);
         d_out_ff <= sd.outside;
         d_re_ff  <= sd.re;
         d_im_ff  <= sd.im;
      end
   end

   // Stage E: phase rounding and quadrant split.
   logic [63:0] phw;
   logic [31:0] ph, rr, phq;
   logic [1:0]  q;
   always_comb begin
      phw = 64'(prod_ff) + 64'd1024;
      ph  = phw[42:11];
      phq = ph + 32'h2000_0000;
      q   = phq[31:30];
      rr  = ph - {q, 30'd0};
   end
   logic e_v_ff, e_out_ff;
   logic [1:0] e_q_ff;
   logic signed [31:0] e_z_ff;
   logic signed [23:0] e_re_ff, e_im_ff;
   always_ff @(posedge clock) begin
      if (reset) e_v_ff <= 1'b0;
      else if (advance) e_v_ff <= d_v_ff;
      if (advance) begin
         e_q_ff <= q; e_z_ff <= rr; e_out_ff <= d_out_ff;
         e_re_ff <= d_re_ff; e_im_ff <= d_im_ff;
      end
   end

   // Stage F: gain compensation and coarse quarter-turn rotation.
   rot_word_type rt_chain [0:CordicStages];
   logic signed [63:0] gx, gy;
   always_comb begin
      gx = e_re_ff * $signed(33'sd2608131496);
      gy = e_im_ff * $signed(33'sd2608131496);
   end
   always_ff @(posedge clock) begin
      if (reset) rt_chain[0].valid <= 1'b0;
      else if (advance) rt_chain[0].valid <= e_v_ff;
      if (advance) begin
         rt_chain[0].outside <= e_out_ff;
         rt_chain[0].pass_re <= e_re_ff;
         rt_chain[0].pass_im <= e_im_ff;
         rt_chain[0].z <= 34'(e_z_ff);
         unique case (e_q_ff)
            2'd1:    begin rt_chain[0].x <= -gy; rt_chain[0].y <= gx;  end
            2'd2:    begin rt_chain[0].x <= -gx; rt_chain[0].y <= -gy; end
            2'd3:    begin rt_chain[0].x <= gy;  rt_chain[0].y <= -gx; end
            default: begin rt_chain[0].x <= gx;  rt_chain[0].y <= gy;  end
         endcase
      end
   end

   // CORDIC cell row.
   for (genvar g = 0; g < CordicStages; g++) begin : g_rot
      wtpr_rot_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .shift(5'(g)), .angle(atan_turns(g)),
         .word_in(rt_chain[g]), .word_out(rt_chain[g+1]));
   end

   // Output register: round half up and saturate.
   function automatic logic signed [23:0] rsat(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v + 64'sh8000_0000) >>> 32;
      if (r > 64'sd8388607) return 24'sh7FFFFF;
      if (r < -64'sd8388608) return 24'sh800000;
      return r[23:0];
   endfunction
   rot_word_type rl;
   logic o_v_ff, o_out_ff;
   logic signed [23:0] o_re_ff, o_im_ff;
   assign rl = rt_chain[CordicStages];
   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else if (advance) o_v_ff <= rl.valid;
      if (advance) begin
         o_out_ff <= rl.outside;
         o_re_ff  <= rl.outside ? rl.pass_re : rsat(rl.x);
         o_im_ff  <= rl.outside ? rl.pass_im : rsat(rl.y);
      end
   end
   assign rsp.valid       = o_v_ff;
   assign rsp.rotated_re  = o_re_ff;
   assign rsp.rotated_im  = o_im_ff;
   assign rsp.outside_sky = o_out_ff;

   // Checks on pipeline control.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.rotated_re))
      else $error("stalled result changed");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("ready mismatch");
   a_flag: assert property (@(posedge clock) disable iff (reset)
      advance && rl.valid && rl.outside |=> rsp.outside_sky)
      else $error("outside flag lost");
endmodule
`default_nettype wire

FILE: sv/wtpr_sqrt_cell.sv
// Square-root cell: one result bit of the integer square root per cycle while advance is high.
`default_nettype none
module wtpr_sqrt_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [5:0]             bit_pos,
   input  wire wtpr_pkg::sqrt_word_type word_in,
   output wtpr_pkg::sqrt_word_type     word_out
);
   import wtpr_pkg::*;
   sqrt_word_type word_ff, word_in_n;
   logic [63:0] trial;
   logic [63:0] root_shift;

   // Restoring step: trial = (root << (bit+1)) + (1 << 2*bit).
   always_comb begin
      root_shift = {32'd0, word_in.root} << (bit_pos + 6'd1);
      trial      = root_shift + (64'd1 << {bit_pos, 1'b0});
      word_in_n  = word_in;
      if (word_in.rem >= trial) begin
         word_in_n.rem  = word_in.rem - trial;
         word_in_n.root = word_in.root | (32'd1 << bit_pos[4:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in_n;
      end
   end
   assign word_out = word_ff;
endmodule
`default_nettype wire

FILE: sv/wtpr_rot_cell.sv
// CORDIC cell: one micro-rotation per cycle while advance is high.
`default_nettype none
module wtpr_rot_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [4:0]            shift,
   input  wire logic [31:0]           angle,
   input  wire wtpr_pkg::rot_word_type word_in,
   output wtpr_pkg::rot_word_type     word_out
);
   import wtpr_pkg::*;
   rot_word_type word_ff, word_in_n;
   logic signed [63:0] dx, dy;

   // Turn toward zero residual angle.
   always_comb begin
      dx = word_in.y >>> shift;
      dy = word_in.x >>> shift;
      word_in_n = word_in;
      if (!word_in.z[33]) begin
         word_in_n.x = word_in.x - dx;
         word_in_n.y = word_in.y + dy;
         word_in_n.z = word_in.z - $signed({2'b00, angle});
      end else begin
         word_in_n.x = word_in.x + dx;
         word_in_n.y = word_in.y - dy;
         word_in_n.z = word_in.z + $signed({2'b00, angle});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in_n;
      end
   end
   assign word_out = word_ff;
endmodule
`default_nettype wire

FILE: test/w_term_phase_rotation_core_tb.sv
// Testbench: random and directed samples through the w-term rotation core, scoreboard checked.
`default_nettype none
module w_term_phase_rotation_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wtpr_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int PipeDepth  = 70;
   localparam int CycleLimit = 600000;

   // Golden phase rotator with its own register copy and a queue of expected words.
   class rotation_scoreboard;
      logic [12:0]        grid_side;
      logic [31:0]        pixel_size;
      logic signed [31:0] w_wl;
      int                 fails;
      longint             exp_re[$];
      longint             exp_im[$];
      bit                 exp_out[$];
      logic [31:0]        arctan[32];

      function new();
         arctan = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
                    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
                    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
         grid_side  = 13'd1024;
         pixel_size = 0;
         w_wl       = 0;
         fails      = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_GRID_SIDE: grid_side = value[12:0];
            REG_PIXEL:     pixel_size = value;
            REG_W:         w_wl = value;
            default: ;
         endcase
      endfunction

      // Append one expected word at the tail of the queues.
      function void queue_word(longint re, longint im, bit outside);
         exp_re  = {exp_re, re};
         exp_im  = {exp_im, im};
         exp_out = {exp_out, outside};
      endfunction

      function logic [63:0] square_q62(logic [63:0] a);
         logic [63:0] h;
         logic [63:0] b;
         if (a >= 64'd1 << 33) return 64'd1 << 62;
         h = a >> 1;
         b = a & 64'd1;
         return (h * h + h * b) >> 2;
      endfunction

      function logic [63:0] floor_sqrt(logic [63:0] v);
         logic [63:0] res;
         logic [63:0] bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function logic [63:0] offset_mag(logic [11:0] idx, longint side);
         longint d;
         d = 2 * longint'(idx) - side;
         if (d < 0) d = -d;
         return 64'(d) * 64'(pixel_size);
      endfunction

      function longint round_clip(longint v);
         longint r;
         r = (v + (64'sd1 <<< 31)) >>> 32;
         if (r > 8388607) r = 8388607;
         if (r < -8388608) r = -8388608;
         return r;
      endfunction

      // Predict the rotated word for one accepted sample and queue it.
      function void note_sample(logic [11:0] row, logic [11:0] col,
                                logic signed [23:0] re, logic signed [23:0] im);
         longint      side;
         logic [63:0] am, al, r, s, prod, ph, q, rr;
         longint      x, y, z, t, dx, dy;
         side = (grid_side > GridSideMax) ? GridSideMax : longint'(grid_side);
         am = offset_mag(row, side);
         al = offset_mag(col, side);
         r  = square_q62(am) + square_q62(al);
         if (am > (64'd1 << 33) || al > (64'd1 << 33) || r > (64'd1 << 62)) begin
            queue_word(re, im, 1'b1);
            return;
         end
         s    = floor_sqrt((64'd1 << 62) - r);
         prod = longint'(w_wl) * (longint'(s) - (64'sd1 <<< 31));
         ph   = ((prod + 64'd1024) >> 11) & 64'hFFFF_FFFF;
         q    = ((ph + 64'h2000_0000) >> 30) & 64'd3;
         rr   = (ph - (q << 30)) & 64'hFFFF_FFFF;
         z    = longint'(rr);
         if (rr >= 64'h8000_0000) z = z - 64'sh1_0000_0000;
         x = longint'(re) * 64'sd2608131496;
         y = longint'(im) * 64'sd2608131496;
         // coarse quarter-turn rotation
         if (q == 1) begin
            t = x; x = -y; y = t;
         end else if (q == 2) begin
            x = -x; y = -y;
         end else if (q == 3) begin
            t = x; x = y; y = -t;
         end
         for (int i = 0; i < CordicStages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx; y = y + dy; z = z - longint'(arctan[i]);
            end else begin
               x = x + dx; y = y - dy; z = z + longint'(arctan[i]);
            end
         end
         queue_word(round_clip(x), round_clip(y), 1'b0);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
         fails++;
      endtask

      // Compare one delivered word against the oldest prediction.
      task check_result(logic signed [23:0] re, logic signed [23:0] im, logic outside);
         longint er, ei;
         bit     eo;
         if (exp_re.size() == 0) begin
            report("unexpected word", 0, 0);
            return;
         end
         er = exp_re.pop_front();
         ei = exp_im.pop_front();
         eo = exp_out.pop_front();
         if (longint'(re) != er) report("rotated_re", re, er);
         if (longint'(im) != ei) report("rotated_im", im, ei);
         if (outside !== eo) report("outside_sky", outside, eo);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   wtpr_req_if req_ch();
   wtpr_rsp_if rsp_ch();

   rotation_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_req = 0;
   int  hold_left = 0;
   int  cycles = 0;

   w_term_phase_rotation_core dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Drive receiver ready: random idling, or a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_req) begin
         hold_req  = 0;
         hold_left = 300;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check each result word while it is stable before its accepting edge.
   always @(negedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.rotated_re, rsp_ch.rotated_im, rsp_ch.outside_sky);
   end

   // Abort on a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAIL w_term_phase_rotation_core");
         $finish;
      end
   end

   task write_reg(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   // Offer one sample word, with a random gap first, and hold it until taken.
   task send_sample(logic [11:0] row, logic [11:0] col,
                    logic signed [23:0] re, logic signed [23:0] im);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.row_index    <= row;
      req_ch.column_index <= col;
      req_ch.sample_re    <= re;
      req_ch.sample_im    <= im;
      forever begin
         @(negedge clock);
         if (req_ch.ready) break;
      end
      sb.note_sample(row, col, re, im);
      @(posedge clock);
   endtask

   // Drop valid and let the pipeline drain before touching registers.
   task drain();
      req_ch.valid <= 1'b0;
      while (sb.exp_re.size() != 0) @(posedge clock);
      repeat (PipeDepth) @(posedge clock);
   endtask

   function automatic logic [11:0] pick_index();
      longint side;
      side = (sb.grid_side > GridSideMax) ? GridSideMax : longint'(sb.grid_side);
      if (side > 0 && $urandom_range(99) < 85) return 12'($urandom_range(side - 1));
      return 12'($urandom);
   endfunction

   // Pick a pixel size that usually places the sky edge near the grid border, else a random one.
   function automatic logic [31:0] pick_pixel();
      longint side;
      longint p;
      side = (sb.grid_side > GridSideMax) ? GridSideMax : longint'(sb.grid_side);
      if (side == 0) side = 1;
      if ($urandom_range(9) == 0) return $urandom;
      p = ((64'sd1 <<< 33) / side) * $urandom_range(160, 40) / 100;
      if (p > 64'sh0FFFF_FFFF) p = 64'sh0FFFF_FFFF;
      return 32'(p);
   endfunction

   task random_items(int count, bit with_hold);
      for (int k = 0; k < count; k++) begin
         if (with_hold && k == count / 3) hold_req = 1;
         send_sample(pick_index(), pick_index(), 24'($urandom), 24'($urandom));
      end
   endtask

   initial begin
      logic [12:0] side_pick;
      logic [31:0] w_pick;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_ch.valid        = 1'b0;
      req_ch.row_index    = '0;
      req_ch.column_index = '0;
      req_ch.sample_re    = '0;
      req_ch.sample_im    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: zero pixel size, so zero phase through the CORDIC.
      send_sample(12'd0, 12'd4095, 24'sh7FFFFF, -24'sd8388608);
      send_sample(12'd512, 12'd512, 24'sd12345, -24'sd1);
      drain();

      // Small grid: sky edge exactly at index 0, outside at the corner.
      write_reg(REG_GRID_SIDE, 32'd64);
      write_reg(REG_PIXEL, 32'h0800_0000);
      write_reg(REG_W, 32'h0012_3456);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      send_sample(12'd32, 12'd0, 24'sh7FFFFF, 24'sh7FFFFF);
      send_sample(12'd0, 12'd32, -24'sd8388608, -24'sd8388608);
      send_sample(12'd0, 12'd0, 24'sd1000, -24'sd1000);
      send_sample(12'd32, 12'd32, 24'sh7FFFFF, -24'sd8388608);
      send_sample(12'd4095, 12'd4095, 24'sd5, 24'sd7);
      send_sample(12'd40, 12'd20, -24'sd1, 24'sd0);
      send_sample(12'd63, 12'd1, 24'sd4000000, 24'sd3000000);
      drain();

      // Largest grid, most negative w.
      write_reg(REG_GRID_SIDE, 32'd4096);
      write_reg(REG_PIXEL, 32'h0020_0000);
      write_reg(REG_W, 32'h8000_0000);
      send_sample(12'd2048, 12'd0, 24'sh7FFFFF, 24'sd0);
      send_sample(12'd1000, 12'd3000, -24'sd8388608, 24'sh7FFFFF);
      send_sample(12'd4095, 12'd2048, 24'sd1, 24'sd1);
      drain();

      // Saturated side, widest pixel, largest w.
      write_reg(REG_GRID_SIDE, 32'h1FFF);
      write_reg(REG_PIXEL, 32'hFFFF_FFFF);
      write_reg(REG_W, 32'h7FFF_FFFF);
      send_sample(12'd2048, 12'd2048, 24'sh7FFFFF, 24'sh7FFFFF);
      send_sample(12'd2049, 12'd2047, 24'sd100, -24'sd100);
      send_sample(12'd0, 12'd4095, 24'sd9, 24'sd9);
      drain();

      // Zero side (centre at index 0), then an odd side.
      write_reg(REG_GRID_SIDE, 32'd0);
      write_reg(REG_PIXEL, 32'h0001_0000);
      send_sample(12'd0, 12'd0, 24'sd777, 24'sd888);
      send_sample(12'd4095, 12'd100, 24'sd777, 24'sd888);
      drain();
      write_reg(REG_GRID_SIDE, 32'd1);
      write_reg(REG_PIXEL, 32'h8000_0000);
      send_sample(12'd0, 12'd0, -24'sd2, 24'sd3);
      drain();

      // Random phases: receiver-heavy idling, then sender-heavy, then none.
      for (int ph = 0; ph < 9; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 28; recv_idle_pct = 64;
         end else if (ph < 6) begin
            send_idle_pct = 64; recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         case ($urandom_range(3))
            0: side_pick = 13'($urandom_range(64, 1));
            1: side_pick = 13'($urandom_range(4096, 1));
            2: side_pick = 13'($urandom);
            default: side_pick = 13'd4096;
         endcase
         w_pick = ($urandom_range(1)) ? $urandom : 32'($signed($urandom_range(8192)) - 4096);
         write_reg(REG_GRID_SIDE, {19'd0, side_pick});
         write_reg(REG_PIXEL, pick_pixel());
         write_reg(REG_W, w_pick);
         random_items(205, ph == 4 || ph == 7);
         drain();
      end

      if (sb.fails == 0) begin
         $display("PASS w_term_phase_rotation_core");
      end else begin
         $display("FAIL w_term_phase_rotation_core");
      end
      $finish;
   end
endmodule
`default_nettype wire
